[rtl/swrl_pkg.sv]
// ----------------------------------------------------------------------------
// swrl_pkg: shared types and constants of the sliding window rate limiter
// Beat layouts, configuration register codes and default sizes.
// ----------------------------------------------------------------------------
package swrl_pkg;

  // Fixed field widths of the beats
  localparam int CUST_ID_W = 8;
  localparam int TS_W      = 32;
  localparam int INWIN_W   = 5;
  localparam int MAXREQ_W  = 5;
  localparam int WINDOW_W  = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Default sizes
  localparam int DEF_NUM_CUSTOMERS = 256;
  localparam int DEF_MAX_SLOTS     = 16;
  localparam int DEF_TIME_WIDTH    = 32;

  // Register reset values
  localparam logic [MAXREQ_W-1:0] RST_MAX_REQUESTS = MAXREQ_W'(5);
  localparam logic [WINDOW_W-1:0] RST_WINDOW_TICKS = WINDOW_W'(5000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_REQUESTS = 1'b0,
    REG_WINDOW_TICKS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CUST_ID_W-1:0] customer_id;
    logic [TS_W-1:0]      timestamp;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic [INWIN_W-1:0] in_window;
  } rsp_t;

  typedef struct packed {
    logic [MAXREQ_W-1:0] max_requests;
    logic [WINDOW_W-1:0] window_ticks;
  } cfg_t;

endpackage

[rtl/sliding_window_rate_limiter.sv]
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter: per-customer sliding-window-log rate limiter
// Keeps a ring of request times per customer, trims stale times and decides
// allow or deny for each request beat.
// ----------------------------------------------------------------------------
// Each request beat names a customer and the present time. The customer's
// ring of stored request times is trimmed, oldest first, of every time whose
// age (present minus stored, modulo 2^TIME_WIDTH) exceeds window_ticks; if
// fewer than max_requests times remain (limit capped at MAX_SLOTS) the request
// is allowed and its time is appended. One response beat per request gives
// the verdict and the ring's new count. Requests are handled one at a time by
// a sequencer around two RAMs with registered read data: a per-customer
// head/count RAM and the stamp RAM. A request is accepted while idle, reads
// its head/count, then, for a non-empty ring, tests stored stamps oldest first
// (one stamp RAM read per popped stamp) and finally decides. A response waiting
// on a stalled output holds the sequencer in its decide step. After reset the
// head/count RAM is cleared, one customer per cycle, while request beats are
// stalled; configuration writes are taken at any time but are meant to be made
// only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int NUM_CUSTOMERS = DEF_NUM_CUSTOMERS,
  parameter int MAX_SLOTS     = DEF_MAX_SLOTS,
  parameter int TIME_WIDTH    = DEF_TIME_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // request channel
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_data,
  // response channel
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp_data
);

  // Derived sizes
  localparam int CIDX_W   = $clog2(NUM_CUSTOMERS);
  localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int COUNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SUM_W    = COUNT_W + 1;
  localparam int META_W   = SLOT_W + COUNT_W;
  localparam int STAMP_D  = NUM_CUSTOMERS * (2 ** SLOT_W);
  localparam int STAMP_AW = $clog2(STAMP_D);
  localparam int CMP_W    = (TIME_WIDTH > WINDOW_W) ? TIME_WIDTH : WINDOW_W;
  localparam int LIM_W    = (COUNT_W > MAXREQ_W) ? COUNT_W : MAXREQ_W;
  localparam int CUST_IDS = 2 ** CUST_ID_W;

  localparam logic [CIDX_W-1:0]  LAST_CUST = CIDX_W'(NUM_CUSTOMERS - 1);
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);
  localparam logic [SUM_W-1:0]   SLOTS_SUM = SUM_W'(MAX_SLOTS);
  localparam logic [LIM_W-1:0]   SLOTS_LIM = LIM_W'(MAX_SLOTS);
  localparam logic [COUNT_W-1:0] ONE_CNT   = COUNT_W'(1);

  typedef enum logic [2:0] {
    S_CLEAR,   // sweeping the head/count RAM after reset
    S_IDLE,    // waiting for a request beat
    S_META,    // head/count of the customer arrive
    S_TRIM,    // one stored stamp arrives per cycle and is tested for age
    S_DECIDE   // verdict, write back, response
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  cfg_t cfg;

  swrl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // --------------------------------------------------------------------------
  // Customer id folding: constant table of id modulo NUM_CUSTOMERS
  // --------------------------------------------------------------------------
  logic [CIDX_W-1:0] cust_map [CUST_IDS];

  for (genvar i = 0; i < CUST_IDS; i++) begin : g_cust_map
    assign cust_map[i] = CIDX_W'(i % NUM_CUSTOMERS);
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  state_t                state;
  logic [CIDX_W-1:0]     clr_idx;
  logic [CIDX_W-1:0]     cust;
  logic [TIME_WIDTH-1:0] now;
  logic [SLOT_W-1:0]     head;
  logic [COUNT_W-1:0]    count;

  // RAM ports
  logic                  meta_we;
  logic [CIDX_W-1:0]     meta_waddr;
  logic [META_W-1:0]     meta_wdata;
  logic [CIDX_W-1:0]     meta_raddr;
  logic [META_W-1:0]     meta_rdata;
  logic                  stamp_we;
  logic [STAMP_AW-1:0]   stamp_waddr;
  logic [STAMP_AW-1:0]   stamp_raddr;
  logic [TIME_WIDTH-1:0] stamp_rdata;

  // Datapath
  logic [SLOT_W-1:0]     meta_head;
  logic [COUNT_W-1:0]    meta_count;
  logic [SLOT_W-1:0]     head_inc;
  logic [SLOT_W-1:0]     rd_slot;
  logic [TIME_WIDTH-1:0] age;
  logic                  stale;
  logic [LIM_W-1:0]      max_ext;
  logic [LIM_W-1:0]      limit;
  logic                  allow;
  logic [SUM_W-1:0]      tail_sum;
  logic [SLOT_W-1:0]     tail;
  logic [COUNT_W-1:0]    count_new;
  logic                  rsp_free;
  logic                  req_take;

  assign {meta_head, meta_count} = meta_rdata;

  assign head_inc = (head == LAST_SLOT) ? '0 : head + SLOT_W'(1);

  // Age test of the stamp just read, modulo 2^TIME_WIDTH
  assign age   = now - stamp_rdata;
  assign stale = CMP_W'(age) > CMP_W'(cfg.window_ticks);

  // Limit capped at the ring size
  assign max_ext = LIM_W'(cfg.max_requests);
  assign limit   = (max_ext > SLOTS_LIM) ? SLOTS_LIM : max_ext;
  assign allow   = LIM_W'(count) < limit;

  // Slot of the append: (head + count) wrapped once
  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SLOTS_SUM) begin
      tail_sum = tail_sum - SLOTS_SUM;
    end
    tail = tail_sum[SLOT_W-1:0];
  end

  assign count_new = allow ? count + ONE_CNT : count;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;

  // Head/count RAM: read at the incoming customer, written by the clearing
  // sweep or at the end of a request
  assign meta_raddr = cust_map[req_data.customer_id];

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = cust;
    meta_wdata = {head, count_new};
    if (state == S_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_idx;
      meta_wdata = '0;
    end else if (state == S_DECIDE && rsp_free) begin
      meta_we = 1'b1;
    end
  end

  // Stamp RAM: the first read takes the stored head, later reads the next slot
  assign rd_slot     = (state == S_META) ? meta_head : head_inc;
  assign stamp_raddr = STAMP_AW'({cust, rd_slot});
  assign stamp_waddr = STAMP_AW'({cust, tail});
  assign stamp_we    = (state == S_DECIDE) && rsp_free && allow;

  swrl_ram #(
    .DEPTH (NUM_CUSTOMERS),
    .WIDTH (META_W)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_waddr),
    .wr_data (meta_wdata),
    .rd_addr (meta_raddr),
    .rd_data (meta_rdata)
  );

  swrl_ram #(
    .DEPTH (STAMP_D),
    .WIDTH (TIME_WIDTH)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (stamp_we),
    .wr_addr (stamp_waddr),
    .wr_data (now),
    .rd_addr (stamp_raddr),
    .rd_data (stamp_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer and response register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // beat taken with no new verdict behind it: output goes empty
      if (rsp_valid && !rsp_stall && state != S_DECIDE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CIDX_W'(1);
          if (clr_idx == LAST_CUST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            cust  <= meta_raddr;
            now   <= TIME_WIDTH'(req_data.timestamp);
            state <= S_META;
          end
        end
        S_META: begin
          head  <= meta_head;
          count <= meta_count;
          // stamp at the head is being read now when the ring is not empty
          state <= (meta_count == '0) ? S_DECIDE : S_TRIM;
        end
        S_TRIM: begin
          if (stale) begin
            head  <= head_inc;
            count <= count - ONE_CNT;
            if (count == ONE_CNT) begin
              state <= S_DECIDE;
            end
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (rsp_free) begin
            rsp_valid          <= 1'b1;
            rsp_data.allowed   <= allow;
            rsp_data.in_window <= INWIN_W'(count_new);
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // an accepted request goes straight on to its head/count read
  a_take_to_meta: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == S_META)
    else $error("accepted request did not move to head/count step");

  // trimming only ever looks at a non-empty ring
  a_trim_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_TRIM |-> count != '0)
    else $error("trim step on an empty ring");

  // a decide step with room on the output leaves a response and returns idle
  a_decide_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && rsp_free) |=> (rsp_valid && state == S_IDLE))
    else $error("decide step did not produce a response");
`endif

endmodule

[rtl/swrl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// swrl_cfg_regs: configuration registers
// Write-only register file holding the request limit and the window length.
// ----------------------------------------------------------------------------
module swrl_cfg_regs
  import swrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_requests <= RST_MAX_REQUESTS;
      cfg.window_ticks <= RST_WINDOW_TICKS;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_REQUESTS: cfg.max_requests <= cfg_data[MAXREQ_W-1:0];
        REG_WINDOW_TICKS: cfg.window_ticks <= cfg_data[WINDOW_W-1:0];
      endcase
    end
  end

endmodule

[rtl/swrl_ram.sv]
// ----------------------------------------------------------------------------
// swrl_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swrl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
